// ----- rtl/kmp_pkg.sv -----
// Shared types and codes of the key macro player.
`default_nettype none
package kmp_pkg;

  typedef enum logic [1:0] {
    CMD_POLL  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_PRESS       = 2'd1,
    ACT_RELEASE     = 2'd2,
    ACT_RELEASE_ALL = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    MODE_COMPLETE   = 4'b0001,
    MODE_RUNNING    = 4'b0010,
    MODE_DELAY      = 4'b0100,
    MODE_DELAY_CHAR = 4'b1000
  } mode_t;

  localparam logic [7:0] OP_END        = 8'd0;
  localparam logic [7:0] OP_DELAY      = 8'd1;
  localparam logic [7:0] OP_PAUSE      = 8'd2;
  localparam logic [7:0] OP_SET_PAUSE  = 8'd3;
  localparam logic [7:0] OP_TAP_KEY    = 8'd4;
  localparam logic [7:0] OP_TAP_CHAR   = 8'd5;
  localparam logic [7:0] OP_DOWN_KEY   = 8'd6;
  localparam logic [7:0] OP_DOWN_CHAR  = 8'd7;
  localparam logic [7:0] OP_UP_KEY     = 8'd8;
  localparam logic [7:0] OP_UP_CHAR    = 8'd9;

  localparam logic [7:0] PAUSE_RESET   = 8'd30;

endpackage
`default_nettype wire

// ----- rtl/kmp_if.sv -----
// Valid/ready channel interfaces for command beats and key action beats.
`default_nettype none
interface kmp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       ms_tick;
  logic [7:0] address;
  logic [7:0] data_byte;

  modport source (output valid, command, ms_tick, address, data_byte, input ready);
  modport sink   (input valid, command, ms_tick, address, data_byte, output ready);
endinterface

interface kmp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_action;
  logic [7:0] key_code;
  logic       key_is_char;
  logic       running;
  logic       finished;

  modport source (output valid, key_action, key_code, key_is_char, running, finished,
                  input ready);
  modport sink   (input valid, key_action, key_code, key_is_char, running, finished,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/key_macro_player.sv -----
// Key macro player: program store, playback sequencer and result register.
// Each accepted command beat gives a registered result beat in the next cycle.
// One beat per cycle unless the result channel back-pressures; the program
// store is prefetched at the counter and the byte after it every cycle, so an
// opcode and operand are ready at once. Reset sets the sequencer to complete,
// pause length and default pause to 30; store contents persist, need no pass.
`default_nettype none
module key_macro_player #(
  parameter int PROG_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  kmp_req_if.sink         req,
  kmp_rsp_if.source       rsp
);
  import kmp_pkg::*;

  localparam int AW = $clog2(PROG_DEPTH);

  function automatic logic [AW-1:0] wrap_addr(input logic [7:0] a);
    logic [11:0] r;
    r = {4'd0, a};
    for (int k = 3; k >= 0; k--) begin
      if (r >= 12'(PROG_DEPTH << k)) begin
        r = r - 12'(PROG_DEPTH << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
    return (a == AW'(PROG_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  logic [7:0]    mem [PROG_DEPTH];
  logic [7:0]    op;
  logic [7:0]    arg;
  logic [AW-1:0] pc, pc_next, pc_inc1, rd_addr1, wr_addr;
  mode_t         mode, mode_next;
  logic [7:0]    wait_rem, wait_next, wait_dec;
  logic [7:0]    pause_len, pause_next;
  logic [7:0]    held_key, held_key_next;
  logic [7:0]    held_char, held_char_next;
  logic [7:0]    default_pause;
  logic          accept, execute, mem_we;
  action_t       act;
  logic [7:0]    code;
  logic          is_char, fin;

  assign accept   = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign wr_addr  = wrap_addr(req.address);
  assign mem_we   = accept && (cmd_t'(req.command) == CMD_LOAD);
  assign pc_inc1  = inc_addr(pc);
  assign rd_addr1 = inc_addr(pc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_pause <= PAUSE_RESET;
    end else if (cfg_we) begin
      default_pause <= cfg_data;
    end
  end

  // store with write forwarding into both prefetch ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= req.data_byte;
    end
    op  <= (mem_we && wr_addr == pc_next)  ? req.data_byte : mem[pc_next];
    arg <= (mem_we && wr_addr == rd_addr1) ? req.data_byte : mem[rd_addr1];
  end

  always_comb begin
    pc_next        = pc;
    mode_next      = mode;
    wait_next      = wait_rem;
    pause_next     = pause_len;
    held_key_next  = held_key;
    held_char_next = held_char;
    act            = ACT_NONE;
    code           = '0;
    is_char        = 1'b0;
    fin            = 1'b0;
    execute        = 1'b0;
    wait_dec       = (req.ms_tick && wait_rem != '0) ? wait_rem - 1'b1 : wait_rem;
    if (accept) begin
      case (cmd_t'(req.command))
        CMD_START: begin
          pc_next        = wrap_addr(req.address);
          mode_next      = MODE_RUNNING;
          wait_next      = '0;
          pause_next     = default_pause;
          held_key_next  = '0;
          held_char_next = '0;
        end
        CMD_POLL: begin
          if (mode != MODE_COMPLETE) begin
            execute = 1'b1;
            if (mode == MODE_DELAY || mode == MODE_DELAY_CHAR) begin
              wait_next = wait_dec;
              if (wait_dec != '0) begin
                execute = 1'b0;
              end else if (mode == MODE_DELAY && held_key != '0) begin
                act           = ACT_RELEASE;
                code          = held_key;
                held_key_next = '0;
                wait_next     = pause_len;
                execute       = 1'b0;
              end else if (mode == MODE_DELAY_CHAR && held_char != '0) begin
                act            = ACT_RELEASE;
                code           = held_char;
                is_char        = 1'b1;
                held_char_next = '0;
                mode_next      = MODE_DELAY;
                wait_next      = pause_len;
                execute        = 1'b0;
              end else begin
                mode_next = MODE_RUNNING;
              end
            end
            if (execute) begin
              pc_next = pc_inc1;
              case (op)
                OP_END: begin
                  mode_next = MODE_COMPLETE;
                  fin       = 1'b1;
                end
                OP_DELAY: begin
                  pc_next   = inc_addr(pc_inc1);
                  wait_next = arg;
                  mode_next = MODE_DELAY;
                end
                OP_PAUSE: begin
                  wait_next = pause_len;
                  mode_next = MODE_DELAY;
                end
                OP_SET_PAUSE: begin
                  pc_next    = inc_addr(pc_inc1);
                  pause_next = arg;
                end
                OP_TAP_KEY: begin
                  pc_next       = inc_addr(pc_inc1);
                  held_key_next = arg;
                  act           = ACT_PRESS;
                  code          = arg;
                  wait_next     = pause_len;
                  mode_next     = MODE_DELAY;
                end
                OP_TAP_CHAR: begin
                  pc_next        = inc_addr(pc_inc1);
                  held_char_next = arg;
                  act            = ACT_PRESS;
                  code           = arg;
                  is_char        = 1'b1;
                  wait_next      = pause_len;
                  mode_next      = MODE_DELAY_CHAR;
                end
                OP_DOWN_KEY, OP_DOWN_CHAR: begin
                  pc_next = inc_addr(pc_inc1);
                  act     = ACT_PRESS;
                  code    = arg;
                  is_char = op[0];
                end
                OP_UP_KEY, OP_UP_CHAR: begin
                  pc_next = inc_addr(pc_inc1);
                  act     = ACT_RELEASE;
                  code    = arg;
                  is_char = op[0];
                end
                default: begin
                  act       = ACT_RELEASE_ALL;
                  mode_next = MODE_COMPLETE;
                  fin       = 1'b1;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      mode      <= MODE_COMPLETE;
      wait_rem  <= '0;
      pause_len <= PAUSE_RESET;
      held_key  <= '0;
      held_char <= '0;
      rsp.valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      mode      <= mode_next;
      wait_rem  <= wait_next;
      pause_len <= pause_next;
      held_key  <= held_key_next;
      held_char <= held_char_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.key_action  <= act;
      rsp.key_code    <= code;
      rsp.key_is_char <= is_char;
      rsp.running     <= (mode_next != MODE_COMPLETE);
      rsp.finished    <= fin;
    end
  end

  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.finished |-> !rsp.running)
    else $error("finished beat still reports running");

  a_no_code_without_key: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.key_action == ACT_NONE || rsp.key_action == ACT_RELEASE_ALL)
    |-> rsp.key_code == 8'd0 && !rsp.key_is_char)
    else $error("key code present without a key action");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == CMD_START
    |=> rsp.valid && rsp.running && rsp.key_action == ACT_NONE && !rsp.finished)
    else $error("start beat did not begin playback");

  a_wait_only_in_delay: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == CMD_POLL && mode == MODE_RUNNING
    && op != OP_DELAY && op != OP_PAUSE && op != OP_TAP_KEY && op != OP_TAP_CHAR
    |=> mode != MODE_DELAY && mode != MODE_DELAY_CHAR)
    else $error("delay entered by an opcode that sets no wait");

endmodule
`default_nettype wire
